/* rtl/core/sht_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package sht_pkg;
   localparam int KeyWidth   = 32;
   localparam int ValueWidth = 64;
   localparam int KindWidth  = 3;
   localparam int StatWidth  = 3;
   localparam int CfgIdxWidth  = 1;
   localparam int CfgDataWidth = 4;

   typedef enum logic [StatWidth-1:0] {
      ST_OK            = 3'd0,
      ST_FULL          = 3'd1,
      ST_EXISTS        = 3'd2,
      ST_NO_STATIC_ROOM = 3'd3,
      ST_REORDER       = 3'd4,
      ST_BAD_KIND      = 3'd5,
      ST_NOT_FOUND     = 3'd6
   } status_type;

   typedef enum logic [KindWidth-1:0] {
      KIND_DATA          = 3'd0,
      KIND_PARENT        = 3'd1,
      KIND_STATIC        = 3'd2,
      KIND_STATIC_PARENT = 3'd3,
      KIND_SETTER        = 3'd4,
      KIND_BAD5          = 3'd5,
      KIND_BAD6          = 3'd6,
      KIND_BAD7          = 3'd7
   } kind_type;

   localparam logic REQ_ADD    = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   localparam logic [CfgIdxWidth-1:0] CSR_TABLE_SIZE_LOG2     = 1'd0;
   localparam logic [CfgIdxWidth-1:0] CSR_STATIC_PARENT_SLOTS = 1'd1;

   typedef enum logic [2:0] {
      S_IDLE, S_CHECK, S_READ, S_EVAL, S_SPREAD, S_WRITE, S_RESP
   } state_type;
endpackage
`default_nettype wire

/* rtl/core/sht_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface sht_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [31:0] key;
   logic [31:0] key_hash;
   logic [2:0]  slot_kind;
   logic [63:0] value;
   modport source (output valid, req_type, key, key_hash, slot_kind, value, input ready);
   modport sink (input valid, req_type, key, key_hash, slot_kind, value, output ready);
endinterface

interface sht_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [2:0]  kind_found;
   logic [63:0] result_value;
   logic        is_instance_index;
   modport source (output valid, status, kind_found, result_value, is_instance_index,
                   input ready);
   modport sink (input valid, status, kind_found, result_value, is_instance_index,
                 output ready);
endinterface

interface sht_csr_if;
   logic       valid;
   logic       ready;
   logic       index;
   logic [3:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/core/slot_hash_table_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// slot hash table core: open-addressed method-slot table with linear probing
// req channel: add (req_type 0) or lookup (req_type 1) request
// rsp channel: one response per request (status, kind, value, index flag)
// csr channel: register 0 table_size_log2, register 1 static_parent_slots;
//   write only while no request is in flight
// one request at a time; a lookup that ends at its first probe goes through
// the check, read and eval states to the response, an add that writes also
// through the write state, and an add refused as full from check straight to
// the response; each further probe adds a spread and an eval state
// (registered memory read, then key compare); the next request is taken in
// idle, which follows the response handshake
// the probe loop over the entry memories sets the rate
// a lookup is bounded at capacity probes
// reset clears the valid bits (flip-flops), the static parent array and the
// counters at once; entry memories need no clearing, so no sweep after reset
// the response is held in a register until rsp.ready; req.ready stays low
// meanwhile, so a stalled receiver stalls the requester
module slot_hash_table_core
   import sht_pkg::*;
#(
   parameter int TABLE_DEPTH        = 256,
   parameter int MAX_STATIC_PARENTS = 8
) (
   input wire logic clock,
   input wire logic reset,
   sht_req_if.sink   req,
   sht_rsp_if.source rsp,
   sht_csr_if.sink   csr
);
   localparam int IdxW  = $clog2(TABLE_DEPTH);
   localparam int CntW  = IdxW + 1;
   localparam int SpW   = (MAX_STATIC_PARENTS > 1) ? $clog2(MAX_STATIC_PARENTS) : 1;
   localparam int MaxLog = IdxW;

   // config registers
   logic [3:0] size_log2_ff, sp_slots_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         size_log2_ff <= 4'd8;
         sp_slots_ff  <= 4'd0;
      end else if (csr.valid) begin
         if (csr.index == CSR_TABLE_SIZE_LOG2) size_log2_ff <= csr.data;
         else sp_slots_ff <= csr.data;
      end
   end
   assign csr.ready = 1'b1;

   // capacity as a mask and a count
   logic [3:0]      eff_log;
   logic [CntW-1:0] cap;
   logic [IdxW-1:0] mask;
   always_comb begin
      eff_log = (32'(size_log2_ff) > MaxLog) ? 4'(MaxLog) : size_log2_ff;
      cap     = CntW'(1) << eff_log;
      mask    = IdxW'(cap - CntW'(1));
   end

   // request latch
   logic            rtype_ff;
   logic [31:0]     key_ff;
   logic [2:0]      kind_ff;
   logic [63:0]     val_ff;
   logic [IdxW-1:0] idx_ff, idx_in;
   logic [CntW-1:0] n_ff, n_in;
   state_type       state_ff, state_in;

   // entry memories
   logic                 valid_ff [TABLE_DEPTH];
   logic                 wr_en;
   logic [63:0]          wr_value;
   logic [31:0]          rd_key;
   logic [2:0]           rd_kind;
   logic [63:0]          rd_value;
   logic                 hit_valid_ff;

   sht_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_key (
      .clock, .wr_en, .wr_addr(idx_ff), .wr_data(key_ff), .rd_addr(idx_ff),
      .rd_data(rd_key));
   sht_ram #(.WIDTH(3), .DEPTH(TABLE_DEPTH)) u_kind (
      .clock, .wr_en, .wr_addr(idx_ff), .wr_data(kind_ff), .rd_addr(idx_ff),
      .rd_data(rd_kind));
   sht_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_value (
      .clock, .wr_en, .wr_addr(idx_ff), .wr_data(wr_value), .rd_addr(idx_ff),
      .rd_data(rd_value));

   // counters and static parent array
   logic [CntW-1:0] used_ff, parents_ff, words_ff;
   logic [63:0]     sp_store_ff [MAX_STATIC_PARENTS];

   // first free static parent entry within the usable limit
   logic [3:0]  sp_limit;
   logic        sp_found;
   logic [SpW-1:0] sp_pos;
   always_comb begin
      sp_limit = (32'(sp_slots_ff) > MAX_STATIC_PARENTS) ? 4'(MAX_STATIC_PARENTS)
                                                          : sp_slots_ff;
      sp_found = 1'b0;
      sp_pos   = '0;
      for (int i = MAX_STATIC_PARENTS - 1; i >= 0; i--) begin
         if (i < 32'(sp_limit) && sp_store_ff[i] == 64'd0) begin
            sp_found = 1'b1;
            sp_pos   = SpW'(i);
         end
      end
   end

   // response register
   logic        rsp_valid_ff;
   logic [2:0]  status_ff, status_in;
   logic [2:0]  kfound_ff, kfound_in;
   logic [63:0] rval_ff, rval_in;
   logic        inst_ff, inst_in;

   // probe outcome of the current entry
   logic cur_valid, cur_match;
   always_comb begin
      cur_valid = hit_valid_ff;
      cur_match = hit_valid_ff && (rd_key == key_ff);
   end

   // add decision, computed at the empty entry
   logic [2:0] add_status;
   always_comb begin
      add_status = ST_OK;
      wr_value   = 64'd0;
      case (kind_ff)
         KIND_STATIC_PARENT: begin
            if (!sp_found) add_status = ST_NO_STATIC_ROOM;
            wr_value = 64'(sp_pos);
         end
         KIND_STATIC: wr_value = val_ff;
         KIND_PARENT: begin
            if (words_ff > parents_ff) add_status = ST_REORDER;
            wr_value = 64'(words_ff);
         end
         KIND_DATA: wr_value = 64'(words_ff);
         default: add_status = ST_BAD_KIND;
      endcase
   end
   assign wr_en = (state_ff == S_WRITE) && (add_status == ST_OK);

   // lookup result from the matched entry
   logic [63:0] look_val;
   logic        look_inst;
   always_comb begin
      look_val  = 64'd0;
      look_inst = 1'b0;
      case (rd_kind)
         KIND_DATA, KIND_PARENT: begin
            look_val  = rd_value;
            look_inst = 1'b1;
         end
         KIND_STATIC, KIND_SETTER: look_val = rd_value;
         KIND_STATIC_PARENT:
            look_val = (rd_value < 64'(MAX_STATIC_PARENTS))
                       ? sp_store_ff[rd_value[SpW-1:0]] : 64'd0;
         default: look_val = 64'd0;
      endcase
   end

   // next state; the probe start is loaded when a request is taken
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      n_in     = n_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               state_in = S_CHECK;
               idx_in   = req.key_hash[IdxW-1:0] & mask;
               n_in     = '0;
            end
         end
         S_CHECK: begin
            if (rtype_ff == REQ_ADD && used_ff >= cap) state_in = S_RESP;
            else state_in = S_READ;
         end
         S_READ: state_in = S_EVAL;
         S_EVAL: begin
            if (!cur_valid) begin
               state_in = (rtype_ff == REQ_ADD) ? S_WRITE : S_RESP;
            end else if (cur_match) begin
               state_in = S_RESP;
            end else if (n_ff + CntW'(1) >= cap) begin
               state_in = S_RESP;
            end else begin
               idx_in   = (idx_ff + IdxW'(1)) & mask;
               n_in     = n_ff + CntW'(1);
               state_in = S_SPREAD;
            end
         end
         S_SPREAD: state_in = S_EVAL;
         S_WRITE: state_in = S_RESP;
         S_RESP: if (rsp.ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // response values
   always_comb begin
      status_in = status_ff;
      kfound_in = kfound_ff;
      rval_in   = rval_ff;
      inst_in   = inst_ff;
      unique case (state_ff)
         S_CHECK: begin
            status_in = ST_FULL;
            kfound_in = 3'd0;
            rval_in   = 64'd0;
            inst_in   = 1'b0;
         end
         S_EVAL: begin
            if (rtype_ff == REQ_ADD) begin
               if (cur_valid && cur_match) status_in = ST_EXISTS;
               else status_in = ST_FULL;
            end else if (cur_match) begin
               status_in = ST_OK;
               kfound_in = rd_kind;
               rval_in   = look_val;
               inst_in   = look_inst;
            end else begin
               status_in = ST_NOT_FOUND;
            end
         end
         S_WRITE: status_in = add_status;
         default: ;
      endcase
   end

   assign req.ready = (state_ff == S_IDLE);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         used_ff      <= '0;
         parents_ff   <= '0;
         words_ff     <= '0;
         hit_valid_ff <= 1'b0;
         for (int i = 0; i < TABLE_DEPTH; i++) valid_ff[i] <= 1'b0;
         for (int i = 0; i < MAX_STATIC_PARENTS; i++) sp_store_ff[i] <= 64'd0;
      end else begin
         state_ff     <= state_in;
         hit_valid_ff <= valid_ff[idx_in];
         if (state_in == S_RESP && state_ff != S_RESP) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
         if (wr_en) begin
            valid_ff[idx_ff] <= 1'b1;
            used_ff <= used_ff + CntW'(1);
            case (kind_ff)
               KIND_PARENT: begin
                  parents_ff <= parents_ff + CntW'(1);
                  words_ff   <= words_ff + CntW'(1);
               end
               KIND_DATA: words_ff <= words_ff + CntW'(1);
               KIND_STATIC_PARENT: sp_store_ff[sp_pos] <= val_ff;
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      kfound_ff <= kfound_in;
      rval_ff   <= rval_in;
      inst_ff   <= inst_in;
      idx_ff    <= idx_in;
      n_ff      <= n_in;
      if (req.valid && req.ready) begin
         rtype_ff <= req.req_type;
         key_ff   <= req.key;
         kind_ff  <= req.slot_kind;
         val_ff   <= req.value;
      end
   end

   assign rsp.valid             = rsp_valid_ff;
   assign rsp.status            = status_ff;
   assign rsp.kind_found        = kfound_ff;
   assign rsp.result_value      = rval_ff;
   assign rsp.is_instance_index = inst_ff;

   // checks
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !req.ready)
      else $error("request taken while response pending");
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CntW'(TABLE_DEPTH))
      else $error("used count beyond depth");
   a_write_empty: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !valid_ff[idx_ff])
      else $error("add overwrote a live entry");
   a_words_order: assert property (@(posedge clock) disable iff (reset)
      parents_ff <= words_ff)
      else $error("parent count exceeds instance words");
endmodule
`default_nettype wire

/* rtl/core/sht_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module sht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 1ps
module tb
   import sht_pkg::*;
();

   localparam int DEPTH      = 256;
   localparam int SP_MAX     = 8;
   localparam int KEY_POOL   = 48;
   localparam int HOLD_LEN   = 300;

   // one request with an optional typed-in response
   typedef struct {
      logic        rtype;
      logic [31:0] key;
      logic [31:0] hash;
      logic [2:0]  kind;
      logic [63:0] value;
      bit          typed;
      logic [2:0]  e_status;
      logic [2:0]  e_kind;
      logic [63:0] e_value;
      logic        e_idx;
   } slot_req_type;

   typedef struct {
      logic [2:0]  status;
      logic [2:0]  kind;
      logic [63:0] value;
      logic        idx;
   } slot_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sht_req_if req ();
   sht_rsp_if rsp ();
   sht_csr_if csr ();

   slot_hash_table_core i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source),
      .csr   (csr.sink)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow copy of the slot table
   bit          tbl_valid [DEPTH];
   logic [31:0] tbl_key   [DEPTH];
   logic [2:0]  tbl_kind  [DEPTH];
   logic [63:0] tbl_val   [DEPTH];
   logic [63:0] sp_store  [SP_MAX];
   int          used_cnt, parent_cnt, word_cnt;
   int          cfg_log2, cfg_sp;

   slot_rsp_type pending_rsp [$];
   logic [31:0] hash_of [logic [31:0]];
   int          mismatches, errors, n_add, n_lookup, n_hit, n_rsp;
   int          status_seen [8];
   bit          hold_req;

   function automatic int table_capacity();
      int c;
      c = 1 << cfg_log2;
      while (c > DEPTH && c > 1) c = c >> 1;
      return c;
   endfunction

   // 1 key hit, 0 empty entry, 2 whole capacity probed
   function automatic int probe_slot(logic [31:0] key, logic [31:0] hash, output int pos);
      int cap;
      int at;
      cap = table_capacity();
      at  = int'(hash & 32'(cap - 1));
      pos = 0;
      for (int n = 0; n < cap; n++) begin
         if (!tbl_valid[at]) begin
            pos = at;
            return 0;
         end
         if (tbl_key[at] == key) begin
            pos = at;
            return 1;
         end
         at = (at + 1) & (cap - 1);
      end
      return 2;
   endfunction

   function automatic logic [2:0] apply_add(slot_req_type r);
      int pos, hit, lim, i;
      if (used_cnt >= table_capacity()) return ST_FULL;
      hit = probe_slot(r.key, r.hash, pos);
      if (hit == 1) return ST_EXISTS;
      if (hit == 2) return ST_FULL;
      case (r.kind)
         KIND_STATIC_PARENT: begin
            lim = (cfg_sp > SP_MAX) ? SP_MAX : cfg_sp;
            for (i = 0; i < lim; i++)
               if (sp_store[i] == 64'd0) break;
            if (i >= lim) return ST_NO_STATIC_ROOM;
            sp_store[i] = r.value;
            tbl_val[pos] = 64'(i);
         end
         KIND_STATIC: tbl_val[pos] = r.value;
         KIND_PARENT: begin
            if (word_cnt > parent_cnt) return ST_REORDER;
            parent_cnt++;
            tbl_val[pos] = 64'(word_cnt);
            word_cnt++;
         end
         KIND_DATA: begin
            tbl_val[pos] = 64'(word_cnt);
            word_cnt++;
         end
         default: return ST_BAD_KIND;
      endcase
      tbl_valid[pos] = 1'b1;
      tbl_key[pos]   = r.key;
      tbl_kind[pos]  = r.kind;
      used_cnt++;
      return ST_OK;
   endfunction

   // expected response of one request; updates the shadow table
   function automatic slot_rsp_type predict_slot(slot_req_type r);
      slot_rsp_type o;
      int pos;
      o = '{status: ST_OK, kind: 3'd0, value: 64'd0, idx: 1'b0};
      if (r.rtype == REQ_ADD) begin
         n_add++;
         o.status = apply_add(r);
         return o;
      end
      n_lookup++;
      if (probe_slot(r.key, r.hash, pos) != 1) begin
         o.status = ST_NOT_FOUND;
         return o;
      end
      n_hit++;
      o.kind = tbl_kind[pos];
      case (tbl_kind[pos])
         KIND_DATA, KIND_PARENT: begin
            o.value = tbl_val[pos];
            o.idx   = 1'b1;
         end
         KIND_STATIC, KIND_SETTER: o.value = tbl_val[pos];
         KIND_STATIC_PARENT:
            o.value = (tbl_val[pos] < SP_MAX) ? sp_store[tbl_val[pos][2:0]] : 64'd0;
         default: o.value = 64'd0;
      endcase
      return o;
   endfunction

   // directed rows at reset settings
   slot_req_type dir_reset [15] = '{
      '{REQ_LOOKUP, 32'd1, 32'd0, KIND_DATA, 64'd0, 1, ST_NOT_FOUND, 3'd0, 64'd0, 1'b0},
      '{REQ_ADD, 32'd10, 32'd5, KIND_PARENT, 64'd0, 1, ST_OK, 3'd0, 64'd0, 1'b0},
      '{REQ_ADD, 32'd1, 32'd0, KIND_DATA, 64'd0, 1, ST_OK, 3'd0, 64'd0, 1'b0},
      '{REQ_ADD, 32'd1, 32'd0, KIND_STATIC, 64'd7, 1, ST_EXISTS, 3'd0, 64'd0, 1'b0},
      '{REQ_ADD, 32'd2, '1, KIND_BAD7, '1, 1, ST_BAD_KIND, 3'd0, 64'd0, 1'b0},
      '{REQ_ADD, 32'd5, 32'd3, KIND_SETTER, 64'd9, 1, ST_BAD_KIND, 3'd0, 64'd0, 1'b0},
      '{REQ_ADD, 32'd6, 32'd3, KIND_BAD5, 64'd9, 1, ST_BAD_KIND, 3'd0, 64'd0, 1'b0},
      '{REQ_ADD, 32'd3, 32'd2, KIND_STATIC_PARENT, 64'd8, 1, ST_NO_STATIC_ROOM,
        3'd0, 64'd0, 1'b0},
      '{REQ_ADD, 32'd4, 32'd9, KIND_PARENT, 64'd0, 1, ST_REORDER, 3'd0, 64'd0, 1'b0},
      '{REQ_ADD, '1, '1, KIND_STATIC, '1, 1, ST_OK, 3'd0, 64'd0, 1'b0},
      '{REQ_LOOKUP, '1, '1, KIND_DATA, 64'd0, 1, ST_OK, KIND_STATIC, '1, 1'b0},
      '{REQ_LOOKUP, 32'd10, 32'd5, KIND_DATA, 64'd0, 1, ST_OK, KIND_PARENT, 64'd0, 1'b1},
      '{REQ_LOOKUP, 32'd1, 32'd0, KIND_DATA, 64'd0, 1, ST_OK, KIND_DATA, 64'd1, 1'b1},
      '{REQ_ADD, 32'd7, 32'd0, KIND_DATA, 64'd0, 0, ST_OK, 3'd0, 64'd0, 1'b0},
      '{REQ_LOOKUP, 32'd7, 32'd0, KIND_DATA, 64'd0, 0, ST_OK, 3'd0, 64'd0, 1'b0}
   };

   // static parents with the limit clamped, including a zero object
   slot_req_type dir_static [5] = '{
      '{REQ_ADD, 32'd20, 32'd100, KIND_STATIC_PARENT, 64'd0, 1, ST_OK, 3'd0, 64'd0, 1'b0},
      '{REQ_ADD, 32'd21, 32'd100, KIND_STATIC_PARENT, 64'h55, 1, ST_OK, 3'd0, 64'd0, 1'b0},
      '{REQ_LOOKUP, 32'd21, 32'd100, KIND_DATA, 64'd0, 0, ST_OK, 3'd0, 64'd0, 1'b0},
      '{REQ_LOOKUP, 32'd20, 32'd100, KIND_DATA, 64'd0, 0, ST_OK, 3'd0, 64'd0, 1'b0},
      '{REQ_ADD, 32'd22, 32'd7, KIND_STATIC_PARENT, '1, 0, ST_OK, 3'd0, 64'd0, 1'b0}
   };

   // shrunk capacity: full table and bounded probe
   slot_req_type dir_shrunk [3] = '{
      '{REQ_ADD, 32'd30, 32'd0, KIND_DATA, 64'd0, 1, ST_FULL, 3'd0, 64'd0, 1'b0},
      '{REQ_LOOKUP, 32'd999, 32'd0, KIND_DATA, 64'd0, 0, ST_OK, 3'd0, 64'd0, 1'b0},
      '{REQ_LOOKUP, 32'd1, 32'd2, KIND_DATA, 64'd0, 0, ST_OK, 3'd0, 64'd0, 1'b0}
   };

   slot_req_type send_q [$];
   int        burst_left;

   // drive requests in bursts; predict each one as it is accepted
   task automatic send_all();
      slot_req_type r;
      slot_rsp_type e;
      while (send_q.size() > 0) begin
         r = send_q.pop_front();
         if (burst_left == 0) begin
            req.valid = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clock);
            burst_left = $urandom_range(1, 12);
         end
         req.req_type  = r.rtype;
         req.key       = r.key;
         req.key_hash  = r.hash;
         req.slot_kind = r.kind;
         req.value     = r.value;
         req.valid     = 1'b1;
         do @(posedge clock); while (!req.ready);
         e = predict_slot(r);
         if (r.typed) e = '{status: r.e_status, kind: r.e_kind, value: r.e_value, idx: r.e_idx};
         pending_rsp.push_back(e);
         burst_left--;
         @(negedge clock);
      end
      req.valid = 1'b0;
   endtask

   task automatic drain();
      while (pending_rsp.size() > 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic csr_write(logic idx, logic [3:0] data);
      csr.index = idx;
      csr.data  = data;
      csr.valid = 1'b1;
      do @(posedge clock); while (!csr.ready);
      if (idx == CSR_TABLE_SIZE_LOG2) cfg_log2 = int'(data);
      else cfg_sp = int'(data);
      @(negedge clock);
      csr.valid = 1'b0;
   endtask

   function automatic slot_req_type random_req();
      slot_req_type r;
      int pick;
      r = '{default: '0};
      r.rtype = $urandom_range(0, 1);
      pick = $urandom_range(0, 9);
      if (pick < 8) r.key = $urandom_range(1, KEY_POOL);
      else r.key = ($urandom() == 0) ? 32'd1 : $urandom();
      // mostly a stable hash per key so lookups can hit
      if (!hash_of.exists(r.key)) hash_of[r.key] = $urandom();
      r.hash = ($urandom_range(0, 9) < 8) ? hash_of[r.key] : $urandom();
      pick = $urandom_range(0, 9);
      if (pick < 4) r.kind = KIND_DATA;
      else if (pick < 5) r.kind = KIND_PARENT;
      else if (pick < 7) r.kind = KIND_STATIC;
      else if (pick < 9) r.kind = KIND_STATIC_PARENT;
      else r.kind = $urandom_range(KIND_SETTER, KIND_BAD7);
      r.value = ($urandom_range(0, 9) == 0) ? 64'd0 : {$urandom(), $urandom()};
      return r;
   endfunction

   // response checker
   always @(posedge clock) begin
      slot_rsp_type e;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_rsp.size() == 0) begin
            errors++;
            $display("unexpected response status=%0d", rsp.status);
         end else begin
            e = pending_rsp.pop_front();
            n_rsp++;
            status_seen[rsp.status]++;
            if (rsp.status !== e.status || rsp.kind_found !== e.kind ||
                rsp.result_value !== e.value || rsp.is_instance_index !== e.idx) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: exp st=%0d kind=%0d val=%h idx=%0d",
                            " got st=%0d kind=%0d val=%h idx=%0d"},
                           e.status, e.kind, e.value, e.idx, rsp.status, rsp.kind_found,
                           rsp.result_value, rsp.is_instance_index);
            end
         end
      end
   end

   // receiver: picks a random stall mode for each run of the inner loop, plus one long hold
   initial begin
      int mode;
      rsp.ready = 1'b0;
      forever begin
         mode = $urandom_range(0, 2);
         for (int c = 0; c < 64; c++) begin
            @(negedge clock);
            if (hold_req) begin
               rsp.ready = 1'b0;
               repeat (HOLD_LEN) @(negedge clock);
               hold_req = 1'b0;
            end
            case (mode)
               0: rsp.ready = 1'b1;
               1: rsp.ready = $urandom_range(0, 1);
               default: rsp.ready = ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   initial begin
      #50ms;
      $display("tb: FAIL");
      $finish;
   end

   initial begin
      int rnd_log2 [6] = '{3, 0, 6, 8, 4, 15};
      int rnd_sp   [6] = '{1, 0, 8, 3, 15, 5};
      req.valid = 1'b0;
      req.req_type = REQ_ADD;
      req.key = '0;
      req.key_hash = '0;
      req.slot_kind = KIND_DATA;
      req.value = '0;
      csr.valid = 1'b0;
      csr.index = CSR_TABLE_SIZE_LOG2;
      csr.data = '0;
      hold_req = 1'b0;
      burst_left = 0;
      cfg_log2 = 8;
      cfg_sp = 0;
      foreach (sp_store[i]) sp_store[i] = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_reset[i]) send_q.push_back(dir_reset[i]);
      send_all();
      drain();
      csr_write(CSR_TABLE_SIZE_LOG2, 4'd15);
      csr_write(CSR_STATIC_PARENT_SLOTS, 4'd15);
      foreach (dir_static[i]) send_q.push_back(dir_static[i]);
      send_all();
      drain();
      csr_write(CSR_TABLE_SIZE_LOG2, 4'd1);
      csr_write(CSR_STATIC_PARENT_SLOTS, 4'd2);
      foreach (dir_shrunk[i]) send_q.push_back(dir_shrunk[i]);
      send_all();
      drain();

      for (int p = 0; p < 6; p++) begin
         csr_write(CSR_TABLE_SIZE_LOG2, 4'(rnd_log2[p]));
         csr_write(CSR_STATIC_PARENT_SLOTS, 4'(rnd_sp[p]));
         for (int n = 0; n < 105; n++) send_q.push_back(random_req());
         if (p == 2) hold_req = 1'b1;
         send_all();
         drain();
      end

      repeat (20) @(posedge clock);
      if (pending_rsp.size() > 0) errors++;
      $display("covered %0d adds and %0d lookups (%0d hits), %0d responses checked",
               n_add, n_lookup, n_hit, n_rsp);
      $display("status counts ok=%0d full=%0d exists=%0d noroom=%0d reorder=%0d bad=%0d miss=%0d",
               status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EXISTS],
               status_seen[ST_NO_STATIC_ROOM], status_seen[ST_REORDER],
               status_seen[ST_BAD_KIND], status_seen[ST_NOT_FOUND]);
      if (mismatches == 0 && errors == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end
endmodule
